// ===== rtl/glsp_pkg.sv =====
// Shared types, field layout and constants for the granular loop stretch player.
// No dependencies; imported by every module of the block.
`default_nettype none
package glsp_pkg;

   localparam int MEMORY_FRAMES_DEF = 131072;
   localparam int GRAIN_LENGTH_DEF  = 2048;

   localparam int FRAC_W    = 32;
   localparam int RATE_W    = 35;
   localparam int STRETCH_W = 12;
   localparam int SAMPLE_W  = 12;
   localparam int WORD_W    = 24;
   localparam int LOOP_W    = 18;
   localparam int ADDR_W    = 17;
   localparam int FRAME_OUT_W = 17;

   localparam int STRETCH_ONE_Q8    = 256;
   localparam int STRETCH_BYPASS_Q8 = (11 * STRETCH_ONE_Q8 + 5) / 10;
   localparam int MIN_LOOP_FRAMES   = 16;
   localparam logic [LOOP_W-1:0] LOOP_RESET = LOOP_W'(131072);

   // request tdata layout, lowest bit first
   localparam int REQ_ADDR_LO    = 0;
   localparam int REQ_WORD_LO    = REQ_ADDR_LO + ADDR_W;
   localparam int REQ_JUMP_LO    = REQ_WORD_LO + WORD_W;
   localparam int REQ_RATE_LO    = REQ_JUMP_LO + ADDR_W;
   localparam int REQ_STRETCH_LO = REQ_RATE_LO + RATE_W;
   localparam int REQ_TDATA_W    = 112;
   localparam int REQ_TUSER_W    = 2;

   // response tdata layout, lowest bit first
   localparam int RSP_LEFT_LO  = 0;
   localparam int RSP_RIGHT_LO = RSP_LEFT_LO + SAMPLE_W;
   localparam int RSP_FRAME_LO = RSP_RIGHT_LO + SAMPLE_W;
   localparam int RSP_TDATA_W  = 48;
   localparam int RSP_TUSER_W  = 1;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_LOAD = 2'd1,
      CMD_JUMP = 2'd2,
      CMD_NONE = 2'd3
   } glsp_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MODP,
      ST_MODP_W,
      ST_SRC,
      ST_SRC_W,
      ST_SEED,
      ST_SEED_W,
      ST_GSEL,
      ST_GADD,
      ST_GMOD,
      ST_GMOD_W,
      ST_RD_A,
      ST_RD_B,
      ST_RD_W,
      ST_MUL_L,
      ST_ADD_L,
      ST_ADD_R,
      ST_ACC,
      ST_GADV,
      ST_AGE,
      ST_DADV,
      ST_OUT
   } glsp_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } glsp_div_status_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/glsp_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Serves every modulo by the loop length and the stretch division. Uses glsp_pkg.
`default_nettype none
module glsp_divider #(
   parameter int DVD_W = 43,
   parameter int DSR_W = 18,
   parameter int CNT_W = 6
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [CNT_W-1:0]           steps,
   input  wire logic [DVD_W-1:0]           dividend,  // left-aligned
   input  wire logic [DSR_W-1:0]           divisor,
   output glsp_pkg::glsp_div_status_type   status,
   output logic      [DVD_W-1:0]           quotient,
   output logic      [DSR_W-1:0]           remainder
);
   import glsp_pkg::*;

   logic             busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] dvd_ff, quo_ff;
   logic [DSR_W-1:0] rem_ff, dsr_ff;
   logic [DSR_W:0]   trial, diff;
   logic             ge;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         rem_ff <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
         quo_ff <= {quo_ff[DVD_W-2:0], ge};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule
`default_nettype wire

// ===== rtl/glsp_sample_ram.sv =====
// Stereo sample memory: one write port, one registered read port.
// Depends on glsp_pkg for the word width.
`default_nettype none
module glsp_sample_ram #(
   parameter int DEPTH  = 131072,
   parameter int AW     = 17
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [glsp_pkg::WORD_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [AW-1:0]               rd_addr,
   output logic      [glsp_pkg::WORD_W-1:0] rd_data
);
   import glsp_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/granular_loop_stretch_player_unit.sv =====
// Top level of the granular loop stretch player: sequencer, playhead and grain state.
// Depends on glsp_pkg, glsp_divider and glsp_sample_ram.
//
//  channel | dir | handshake          | payload
//  req     | in  | tvalid/tready      | tuser: command; tdata: address, word, jump, rate, stretch
//  rsp     | out | tvalid/tready      | tuser: stretch_active; tdata: left, right, playhead frame
//  csr     | in  | wr_en              | wr_data: loop_frames
//
// Load, jump and idle commands complete without leaving IDLE. A direct tick reduces the
// playhead modulo the loop length in the shared divider, then reads and interpolates two frames.
// A grain tick adds the stretch division, a seed modulo on the first grain tick,
// and per sounding grain one modulo plus two memory reads.
// Synchronous reset restores playhead, grain state and loop length; the memory is not cleared.
// A result waits in the output register while the next transaction is accepted.
`default_nettype none
module granular_loop_stretch_player_unit #(
   parameter int MEMORY_FRAMES = glsp_pkg::MEMORY_FRAMES_DEF,
   parameter int GRAIN_LENGTH  = glsp_pkg::GRAIN_LENGTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata: sample_address, sample_word, jump_frame, rate_increment, stretch_factor
   input  wire logic [glsp_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: command
   input  wire logic [glsp_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: left_out, right_out, playhead_frame
   output logic      [glsp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser: stretch_active
   output logic      [glsp_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  wire logic                            csr_wr_en,
   input  wire logic [glsp_pkg::LOOP_W-1:0]      csr_wr_data
);
   import glsp_pkg::*;

   localparam int FRAME_W = $clog2(MEMORY_FRAMES);
   localparam int N_W     = FRAME_W + 1;
   localparam int PH_W    = FRAME_W + FRAC_W;
   localparam int LEN_W   = N_W + FRAC_W;
   localparam int AGE_W   = $clog2(GRAIN_LENGTH);
   localparam int HOP     = GRAIN_LENGTH / 2;
   localparam int SH      = $clog2(HOP + 1) - 1;
   localparam int MULX_W  = AGE_W + RATE_W;
   localparam int XS_W    = max_int(PH_W, MULX_W) + 1;
   localparam int XI_W    = XS_W - FRAC_W;
   localparam int AMT_W   = RATE_W + AGE_W;
   localparam int AI_W    = AMT_W - FRAC_W;
   localparam int SRC_W   = RATE_W + 8;
   localparam int DVD_W   = max_int(SRC_W, max_int(XI_W, max_int(AI_W, FRAME_W)));
   localparam int DSR_W   = max_int(N_W, STRETCH_W);
   localparam int CNT_W   = $clog2(DVD_W + 1);
   localparam int CMP_W   = max_int(max_int(LOOP_W, N_W), ADDR_W + 1);
   localparam int ACC_W   = SAMPLE_W + AGE_W + 2;
   localparam int LP_W    = SAMPLE_W + 1 + FRAC_W + 1;

   glsp_state_type state_ff, state_in;

   logic [LOOP_W-1:0]   loop_ff;
   logic [PH_W-1:0]     phase_ff;
   logic [PH_W-1:0]     gstart_ff [2];
   logic [RATE_W-1:0]   ginc_ff [2];
   logic [AGE_W-1:0]    gage_ff [2];
   logic                gvalid_ff;
   logic                g_ff;
   logic [RATE_W-1:0]   rate_ff, srcinc_ff;
   logic [STRETCH_W-1:0] stretch_ff;
   logic [PH_W-1:0]     x_ff;
   logic [MULX_W-1:0]   mulx_ff;
   logic [XS_W-1:0]     xsum_ff;
   logic [WORD_W-1:0]   wa_ff, wb_ff;
   logic signed [LP_W-1:0]     lprod_ff;
   logic signed [SAMPLE_W-1:0] lerp_l_ff, lerp_r_ff;
   logic signed [ACC_W-1:0]    sl_ff, sr_ff;
   logic                rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TUSER_W-1:0] rsp_user_ff;

   // loop length, clamped
   logic [CMP_W-1:0] loop_cmp;
   logic [N_W-1:0]   n_frames;
   logic [LEN_W-1:0] len;

   always_comb begin
      loop_cmp = CMP_W'(loop_ff);
      if (loop_cmp < CMP_W'(MIN_LOOP_FRAMES)) begin
         n_frames = N_W'(MIN_LOOP_FRAMES);
      end else if (loop_cmp > CMP_W'(MEMORY_FRAMES)) begin
         n_frames = N_W'(MEMORY_FRAMES);
      end else begin
         n_frames = N_W'(loop_ff);
      end
   end
   assign len = {n_frames, {FRAC_W{1'b0}}};

   // request fields
   glsp_cmd_type         req_cmd;
   logic [ADDR_W-1:0]    req_addr, req_jump;
   logic [WORD_W-1:0]    req_word;
   logic [RATE_W-1:0]    req_rate;
   logic [STRETCH_W-1:0] req_stretch;
   logic                 req_accept;

   assign req_cmd     = glsp_cmd_type'(req_tuser);
   assign req_addr    = req_tdata[REQ_ADDR_LO +: ADDR_W];
   assign req_word    = req_tdata[REQ_WORD_LO +: WORD_W];
   assign req_jump    = req_tdata[REQ_JUMP_LO +: ADDR_W];
   assign req_rate    = req_tdata[REQ_RATE_LO +: RATE_W];
   assign req_stretch = req_tdata[REQ_STRETCH_LO +: STRETCH_W];
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;

   logic active;
   assign active = stretch_ff >= STRETCH_W'(STRETCH_BYPASS_Q8);

   // jump target, saturated to the last loop frame
   logic [N_W-1:0]     last_frame;
   logic [FRAME_W-1:0] jump_sat;
   assign last_frame = n_frames - 1'b1;
   assign jump_sat = (CMP_W'(req_jump) > CMP_W'(last_frame)) ? FRAME_W'(last_frame)
                                                             : FRAME_W'(req_jump);

   // divider
   logic                 div_start;
   logic [CNT_W-1:0]     div_steps;
   logic [DVD_W-1:0]     div_dividend;
   logic [DSR_W-1:0]     div_divisor;
   glsp_div_status_type  div_st;
   logic [DVD_W-1:0]     div_quo;
   logic [DSR_W-1:0]     div_rem;

   glsp_divider #(.DVD_W(DVD_W), .DSR_W(DSR_W), .CNT_W(CNT_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .steps     (div_steps),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_st),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // sample memory
   logic                 ram_wr_en, ram_rd_en;
   logic [FRAME_W-1:0]   ram_rd_addr;
   logic [WORD_W-1:0]    ram_rd_data;
   logic [FRAME_W-1:0]   rd_f, rd_nf;
   logic [N_W-1:0]       rd_f_inc;

   assign ram_wr_en = req_accept && (req_cmd == CMD_LOAD)
                      && (32'(req_addr) < 32'(MEMORY_FRAMES));
   assign rd_f      = x_ff[PH_W-1:FRAC_W];
   assign rd_f_inc  = N_W'(rd_f) + 1'b1;
   assign rd_nf     = (rd_f_inc < n_frames) ? FRAME_W'(rd_f_inc) : '0;

   glsp_sample_ram #(.DEPTH(MEMORY_FRAMES), .AW(FRAME_W)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (FRAME_W'(req_addr)),
      .wr_data (req_word),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // grain weight and products
   logic [AGE_W-1:0]     age_sel, weight;
   logic [AMT_W-1:0]     hop_amt;
   logic [PH_W-1:0]      amt, seed_start;
   assign age_sel = gage_ff[g_ff];
   assign weight  = (32'(age_sel) <= 32'(HOP)) ? age_sel : AGE_W'(GRAIN_LENGTH - 32'(age_sel));
   assign hop_amt = AMT_W'(rate_ff) * AMT_W'(HOP);
   assign amt     = {div_rem[FRAME_W-1:0], hop_amt[FRAC_W-1:0]};
   assign seed_start = (phase_ff >= amt) ? phase_ff - amt
                                         : PH_W'(len - LEN_W'(amt - phase_ff));

   logic signed [SAMPLE_W:0] sa_l, sb_l, sa_r, sb_r, mul_diff;
   logic signed [LP_W-1:0]   mul_out;
   assign sa_l = SAMPLE_W'(signed'(wa_ff[SAMPLE_W-1:0]));
   assign sb_l = SAMPLE_W'(signed'(wb_ff[SAMPLE_W-1:0]));
   assign sa_r = SAMPLE_W'(signed'(wa_ff[WORD_W-1:SAMPLE_W]));
   assign sb_r = SAMPLE_W'(signed'(wb_ff[WORD_W-1:SAMPLE_W]));
   assign mul_diff = (state_ff == ST_MUL_L) ? (sb_l - sa_l) : (sb_r - sa_r);
   assign mul_out  = LP_W'(mul_diff) * LP_W'(signed'({1'b0, x_ff[FRAC_W-1:0]}));

   logic signed [SAMPLE_W+1:0] lerp_l_sum, lerp_r_sum;
   assign lerp_l_sum = (SAMPLE_W+2)'(sa_l) + lprod_ff[LP_W-1:FRAC_W];
   assign lerp_r_sum = (SAMPLE_W+2)'(sa_r) + lprod_ff[LP_W-1:FRAC_W];

   logic signed [AGE_W:0]       w_s;
   logic signed [ACC_W-1:0]     acc_l, acc_r;
   assign w_s   = signed'({1'b0, weight});
   assign acc_l = ACC_W'(lerp_l_ff) * ACC_W'(w_s);
   assign acc_r = ACC_W'(lerp_r_ff) * ACC_W'(w_s);

   // playhead advance with one wrap
   logic [RATE_W-1:0] adv_inc;
   logic [LEN_W-1:0]  adv_sum, adv_next;
   assign adv_inc  = (state_ff == ST_DADV) ? rate_ff : srcinc_ff;
   assign adv_sum  = LEN_W'(phase_ff) + LEN_W'(adv_inc);
   assign adv_next = (adv_sum >= len) ? adv_sum - len : adv_sum;

   logic signed [ACC_W-1:0] sl_sh, sr_sh;
   assign sl_sh = sl_ff >>> SH;
   assign sr_sh = sr_ff >>> SH;

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   localparam int SHIFT_PH   = DVD_W - FRAME_W;
   localparam int SHIFT_SRC  = DVD_W - SRC_W;
   localparam int SHIFT_AMT  = DVD_W - AI_W;
   localparam int SHIFT_X    = DVD_W - XI_W;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_steps    = CNT_W'(FRAME_W);
      div_dividend = DVD_W'(phase_ff[PH_W-1:FRAC_W]) << SHIFT_PH;
      div_divisor  = DSR_W'(n_frames);
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_f;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_cmd == CMD_TICK)) begin
               state_in = ST_MODP;
            end
         end
         ST_MODP: begin
            div_start = 1'b1;
            state_in  = ST_MODP_W;
         end
         ST_MODP_W: begin
            if (div_st.done) begin
               state_in = active ? ST_SRC : ST_RD_A;
            end
         end
         ST_SRC: begin
            div_start    = 1'b1;
            div_steps    = CNT_W'(SRC_W);
            div_dividend = DVD_W'({rate_ff, 8'd0}) << SHIFT_SRC;
            div_divisor  = DSR_W'(stretch_ff);
            state_in     = ST_SRC_W;
         end
         ST_SRC_W: begin
            if (div_st.done) begin
               state_in = gvalid_ff ? ST_GSEL : ST_SEED;
            end
         end
         ST_SEED: begin
            div_start    = 1'b1;
            div_steps    = CNT_W'(AI_W);
            div_dividend = DVD_W'(hop_amt[AMT_W-1:FRAC_W]) << SHIFT_AMT;
            state_in     = ST_SEED_W;
         end
         ST_SEED_W: begin
            if (div_st.done) begin
               state_in = ST_GSEL;
            end
         end
         ST_GSEL: begin
            if (weight != '0) begin
               state_in = ST_GADD;
            end else if (g_ff) begin
               state_in = ST_GADV;
            end
         end
         ST_GADD: state_in = ST_GMOD;
         ST_GMOD: begin
            div_start    = 1'b1;
            div_steps    = CNT_W'(XI_W);
            div_dividend = DVD_W'(xsum_ff[XS_W-1:FRAC_W]) << SHIFT_X;
            state_in     = ST_GMOD_W;
         end
         ST_GMOD_W: begin
            if (div_st.done) begin
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            ram_rd_en = 1'b1;
            state_in  = ST_RD_B;
         end
         ST_RD_B: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = rd_nf;
            state_in    = ST_RD_W;
         end
         ST_RD_W:  state_in = ST_MUL_L;
         ST_MUL_L: state_in = ST_ADD_L;
         ST_ADD_L: state_in = ST_ADD_R;
         ST_ADD_R: state_in = active ? ST_ACC : ST_DADV;
         ST_ACC:   state_in = g_ff ? ST_GADV : ST_GSEL;
         ST_GADV:  state_in = ST_AGE;
         ST_AGE:   state_in = ST_OUT;
         ST_DADV:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // architectural state
   logic [AGE_W:0] age_next [2];
   always_comb begin
      for (int g = 0; g < 2; g++) begin
         age_next[g] = (AGE_W+1)'(gage_ff[g]) + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_ff      <= LOOP_RESET;
         phase_ff     <= '0;
         gstart_ff[0] <= '0;
         gstart_ff[1] <= '0;
         ginc_ff[0]   <= RATE_W'(64'd1 << FRAC_W);
         ginc_ff[1]   <= RATE_W'(64'd1 << FRAC_W);
         gage_ff[0]   <= '0;
         gage_ff[1]   <= AGE_W'(HOP);
         gvalid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            loop_ff <= csr_wr_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_cmd == CMD_JUMP)) begin
                  phase_ff  <= {jump_sat, {FRAC_W{1'b0}}};
                  gvalid_ff <= 1'b0;
               end
            end
            ST_MODP_W: begin
               if (div_st.done) begin
                  phase_ff <= {div_rem[FRAME_W-1:0], phase_ff[FRAC_W-1:0]};
                  if (!active) begin
                     gvalid_ff <= 1'b0;
                  end
               end
            end
            ST_SEED_W: begin
               if (div_st.done) begin
                  gstart_ff[0] <= phase_ff;
                  gstart_ff[1] <= seed_start;
                  ginc_ff[0]   <= rate_ff;
                  ginc_ff[1]   <= rate_ff;
                  gage_ff[0]   <= '0;
                  gage_ff[1]   <= AGE_W'(HOP);
                  gvalid_ff    <= 1'b1;
               end
            end
            ST_GADV, ST_DADV: phase_ff <= adv_next[PH_W-1:0];
            ST_AGE: begin
               // a grain that runs out restarts at the advanced playhead
               for (int g = 0; g < 2; g++) begin
                  if (age_next[g] == (AGE_W+1)'(GRAIN_LENGTH)) begin
                     gstart_ff[g] <= phase_ff;
                     ginc_ff[g]   <= rate_ff;
                     gage_ff[g]   <= '0;
                  end else begin
                     gage_ff[g]   <= age_next[g][AGE_W-1:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            rate_ff    <= req_rate;
            stretch_ff <= req_stretch;
         end
         ST_MODP_W: x_ff <= {div_rem[FRAME_W-1:0], phase_ff[FRAC_W-1:0]};
         ST_SRC_W: begin
            srcinc_ff <= div_quo[RATE_W-1:0];
            sl_ff     <= '0;
            sr_ff     <= '0;
            g_ff      <= 1'b0;
         end
         ST_GSEL: begin
            mulx_ff <= MULX_W'(age_sel) * MULX_W'(ginc_ff[g_ff]);
            if (weight == '0) begin
               g_ff <= 1'b1;
            end
         end
         ST_GADD:  xsum_ff <= XS_W'(gstart_ff[g_ff]) + XS_W'(mulx_ff);
         ST_GMOD_W: x_ff <= {div_rem[FRAME_W-1:0], xsum_ff[FRAC_W-1:0]};
         ST_RD_B:  wa_ff <= ram_rd_data;
         ST_RD_W:  wb_ff <= ram_rd_data;
         ST_MUL_L: lprod_ff <= mul_out;
         ST_ADD_L: begin
            lerp_l_ff <= lerp_l_sum[SAMPLE_W-1:0];
            lprod_ff  <= mul_out;
         end
         ST_ADD_R: lerp_r_ff <= lerp_r_sum[SAMPLE_W-1:0];
         ST_ACC: begin
            sl_ff <= sl_ff + acc_l;
            sr_ff <= sr_ff + acc_r;
            g_ff  <= 1'b1;
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_data_ff <= '0;
         rsp_data_ff[RSP_LEFT_LO +: SAMPLE_W]  <= active ? sl_sh[SAMPLE_W-1:0] : lerp_l_ff;
         rsp_data_ff[RSP_RIGHT_LO +: SAMPLE_W] <= active ? sr_sh[SAMPLE_W-1:0] : lerp_r_ff;
         rsp_data_ff[RSP_FRAME_LO +: FRAME_OUT_W] <= FRAME_OUT_W'(phase_ff[PH_W-1:FRAC_W]);
         rsp_user_ff <= RSP_TUSER_W'(active);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

// ===== rtl/glsp_checker.sv =====
// Port-level checks for the granular loop stretch player, bound to the top level.
// Depends on glsp_pkg and granular_loop_stretch_player_unit.
`default_nettype none
module glsp_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [glsp_pkg::REQ_TUSER_W-1:0] req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [glsp_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import glsp_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_TICK) |=> !req_tready)
      else $error("ready right after a tick transaction");

   a_no_result_from_load_jump: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != CMD_TICK) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result produced by a non-tick transaction");

endmodule

bind granular_loop_stretch_player_unit glsp_checker u_glsp_checker (.*);
`default_nettype wire

// ===== bench/glsp_playback_checker.sv =====
// Checker for the granular loop stretch player: watches the request, response and csr channels,
// predicts each rendered frame and compares it field by field.
// Depends on glsp_pkg for widths, field offsets and command codes.
`timescale 1ns / 100ps
module glsp_playback_checker
   import glsp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic [RSP_TUSER_W-1:0] rsp_tuser,
   input  wire logic                   csr_wr_en,
   input  wire logic [LOOP_W-1:0]      csr_wr_data,
   output int                          pending,
   output int                          error_count,
   output int                          frames_seen,
   output int                          grain_frames
);

   localparam int MEM_FRAMES = MEMORY_FRAMES_DEF;
   localparam int GRAIN_LEN  = GRAIN_LENGTH_DEF;
   localparam int HOP        = GRAIN_LEN / 2;
   localparam int HOP_SHIFT  = $clog2(HOP);

   typedef struct {
      logic [SAMPLE_W-1:0]    left;
      logic [SAMPLE_W-1:0]    right;
      logic [FRAME_OUT_W-1:0] frame;
      logic                   active;
   } frame_t;

   frame_t          frames_due[$];
   logic [WORD_W-1:0] sample_ram [0:MEM_FRAMES-1];
   bit [63:0]       playhead;
   bit [63:0]       grain_start [2];
   bit [63:0]       grain_inc [2];
   int unsigned     grain_age [2];
   bit              grains_live;
   bit [LOOP_W-1:0] loop_reg;
   int              errs;
   int              seen;
   int              grains;

   function automatic bit [63:0] loop_len();
      bit [63:0] n;
      n = loop_reg;
      if (n < MIN_LOOP_FRAMES) n = MIN_LOOP_FRAMES;
      if (n > MEM_FRAMES) n = MEM_FRAMES;
      return n << 32;
   endfunction

   function automatic int interp(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                 bit [31:0] frac);
      int        sa;
      int        sb;
      longint    prod;
      sa = int'($signed(a));
      sb = int'($signed(b));
      prod = longint'(sb - sa) * longint'({32'b0, frac});
      return sa + int'(prod >>> 32);
   endfunction

   task automatic read_frame(input bit [63:0] phase, output int l, output int r);
      bit [63:0]         len;
      int unsigned       f;
      int unsigned       nf;
      logic [WORD_W-1:0] wa;
      logic [WORD_W-1:0] wb;
      len = loop_len();
      phase = phase % len;
      f = phase[63:32];
      nf = (f + 1 < len[63:32]) ? f + 1 : 0;
      wa = sample_ram[f];
      wb = sample_ram[nf];
      l = interp(wa[11:0], wb[11:0], phase[31:0]);
      r = interp(wa[23:12], wb[23:12], phase[31:0]);
   endtask

   task automatic render_tick(input bit [RATE_W-1:0] rate, input bit [STRETCH_W-1:0] stretch,
                              output frame_t res);
      bit [63:0]   len;
      bit [63:0]   src_inc;
      bit [63:0]   back;
      bit [63:0]   ph;
      int          l;
      int          r;
      int          gl;
      int          gr;
      int          sl;
      int          sr;
      int unsigned w;
      len = loop_len();
      l = 0;
      r = 0;
      sl = 0;
      sr = 0;
      playhead = playhead % len;
      res.active = (stretch >= STRETCH_BYPASS_Q8);
      if (!res.active) begin
         grains_live = 0;
         read_frame(playhead, l, r);
         playhead = (playhead + rate) % len;
      end else begin
         src_inc = ({29'b0, rate} << 8) / stretch;
         if (!grains_live) begin
            grain_start[0] = playhead;
            grain_inc[0] = rate;
            grain_age[0] = 0;
            // second grain begins half a grain of source earlier, wrapped into the loop
            ph = playhead % len;
            back = (64'(HOP) * rate) % len;
            grain_start[1] = (ph >= back) ? ph - back : len - (back - ph);
            grain_inc[1] = rate;
            grain_age[1] = HOP;
            grains_live = 1;
         end
         for (int g = 0; g < 2; g++) begin
            if (grain_age[g] >= GRAIN_LEN) w = 0;
            else if (grain_age[g] <= HOP) w = grain_age[g];
            else w = GRAIN_LEN - grain_age[g];
            if (w != 0) begin
               read_frame(grain_start[g] + 64'(grain_age[g]) * grain_inc[g], gl, gr);
               sl += gl * int'(w);
               sr += gr * int'(w);
            end
         end
         playhead = (playhead + src_inc) % len;
         for (int g = 0; g < 2; g++) begin
            grain_age[g]++;
            if (grain_age[g] >= GRAIN_LEN) begin
               grain_start[g] = playhead;
               grain_inc[g] = rate;
               grain_age[g] = 0;
            end
         end
         l = sl >>> HOP_SHIFT;
         r = sr >>> HOP_SHIFT;
      end
      res.left = l[11:0];
      res.right = r[11:0];
      res.frame = playhead[32 +: FRAME_OUT_W];
   endtask

   always @(posedge clock) begin
      logic [ADDR_W-1:0] addr;
      bit [63:0]         target;
      bit [63:0]         last;
      frame_t            res;
      frame_t            want;
      if (reset) begin
         playhead = 0;
         grain_start[0] = 0;
         grain_start[1] = 0;
         grain_inc[0] = 64'd1 << 32;
         grain_inc[1] = 64'd1 << 32;
         grain_age[0] = 0;
         grain_age[1] = HOP;
         grains_live = 0;
         loop_reg = LOOP_RESET;
         frames_due.delete();
      end else begin
         if (csr_wr_en) loop_reg = csr_wr_data;
         if (req_tvalid && req_tready) begin
            case (glsp_cmd_type'(req_tuser))
               CMD_LOAD: begin
                  addr = req_tdata[REQ_ADDR_LO +: ADDR_W];
                  if (addr < MEM_FRAMES) sample_ram[addr] = req_tdata[REQ_WORD_LO +: WORD_W];
               end
               CMD_JUMP: begin
                  target = req_tdata[REQ_JUMP_LO +: ADDR_W];
                  last = (loop_len() >> 32) - 1;
                  if (target > last) target = last;
                  playhead = target << 32;
                  grains_live = 0;
               end
               CMD_TICK: begin
                  render_tick(req_tdata[REQ_RATE_LO +: RATE_W],
                              req_tdata[REQ_STRETCH_LO +: STRETCH_W], res);
                  frames_due.push_back(res);
               end
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (frames_due.size() == 0) begin
               errs++;
               $display("%0t: unexpected frame, expected none, got %h/%h", $time,
                        rsp_tdata, rsp_tuser);
            end else begin
               want = frames_due.pop_front();
               seen++;
               if (want.active) grains++;
               if (rsp_tdata[RSP_LEFT_LO +: SAMPLE_W] !== want.left) begin
                  errs++;
                  $display("%0t: left expected %h got %h", $time, want.left,
                           rsp_tdata[RSP_LEFT_LO +: SAMPLE_W]);
               end
               if (rsp_tdata[RSP_RIGHT_LO +: SAMPLE_W] !== want.right) begin
                  errs++;
                  $display("%0t: right expected %h got %h", $time, want.right,
                           rsp_tdata[RSP_RIGHT_LO +: SAMPLE_W]);
               end
               if (rsp_tdata[RSP_FRAME_LO +: FRAME_OUT_W] !== want.frame) begin
                  errs++;
                  $display("%0t: playhead frame expected %0d got %0d", $time, want.frame,
                           rsp_tdata[RSP_FRAME_LO +: FRAME_OUT_W]);
               end
               if (rsp_tuser[0] !== want.active) begin
                  errs++;
                  $display("%0t: stretch flag expected %b got %b", $time, want.active,
                           rsp_tuser[0]);
               end
            end
         end
      end
      pending <= frames_due.size();
      error_count <= errs;
      frames_seen <= seen;
      grain_frames <= grains;
   end

   initial begin
      errs = 0;
      seen = 0;
      grains = 0;
      pending = 0;
      error_count = 0;
      frames_seen = 0;
      grain_frames = 0;
   end

endmodule

// ===== bench/granular_loop_stretch_player_unit_tb.sv =====
// Testbench top for the granular loop stretch player: clock, reset, stimulus and verdict.
// Depends on glsp_pkg, the player RTL and glsp_playback_checker.
`timescale 1ns / 100ps
module granular_loop_stretch_player_unit_tb;
   import glsp_pkg::*;

   localparam int MEM_FRAMES = MEMORY_FRAMES_DEF;

   typedef struct {
      bit [ADDR_W-1:0]    addr;
      bit [WORD_W-1:0]    word;
      bit [ADDR_W-1:0]    jump;
      bit [RATE_W-1:0]    rate;
      bit [STRETCH_W-1:0] stretch;
   } req_fields_t;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_tvalid = 0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_wr_en = 0;
   logic [LOOP_W-1:0]      csr_wr_data = '0;

   int  pending;
   int  error_count;
   int  frames_seen;
   int  grain_frames;
   bit  no_idle;
   bit  hold_request;
   int  items_sent;
   int  loop_settings;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   granular_loop_stretch_player_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   glsp_playback_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .error_count (error_count),
      .frames_seen (frames_seen),
      .grain_frames(grain_frames)
   );

   function automatic bit [RATE_W-1:0] pick_rate();
      bit [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0:       return v[RATE_W-1:0];
         1:       return {$urandom_range(0, 1), v[31:0]};
         2:       return RATE_W'($urandom_range(0, 7)) << 32;
         3:       return $urandom_range(0, 1) ? '1 : '0;
         default: return v[31:0];
      endcase
   endfunction

   function automatic req_fields_t random_fields();
      req_fields_t f;
      bit [63:0]   v;
      v = {$urandom, $urandom};
      f.addr = $urandom;
      f.word = $urandom;
      f.jump = $urandom;
      f.rate = v[RATE_W-1:0];
      f.stretch = $urandom;
      return f;
   endfunction

   // valid stays high across back-to-back transactions; it is only lowered ahead of a gap
   task automatic send(input glsp_cmd_type cmd, input req_fields_t f);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= '0;
      req_tdata[REQ_ADDR_LO +: ADDR_W] <= f.addr;
      req_tdata[REQ_WORD_LO +: WORD_W] <= f.word;
      req_tdata[REQ_JUMP_LO +: ADDR_W] <= f.jump;
      req_tdata[REQ_RATE_LO +: RATE_W] <= f.rate;
      req_tdata[REQ_STRETCH_LO +: STRETCH_W] <= f.stretch;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic tick(input bit [RATE_W-1:0] rate, input bit [STRETCH_W-1:0] stretch);
      req_fields_t f;
      f = random_fields();
      f.rate = rate;
      f.stretch = stretch;
      send(CMD_TICK, f);
   endtask

   task automatic jump_to(input bit [ADDR_W-1:0] frame);
      req_fields_t f;
      f = random_fields();
      f.jump = frame;
      send(CMD_JUMP, f);
   endtask

   task automatic load(input bit [ADDR_W-1:0] addr, input bit [WORD_W-1:0] word);
      req_fields_t f;
      f = random_fields();
      f.addr = addr;
      f.word = word;
      send(CMD_LOAD, f);
   endtask

   // drain results, then give a possibly running tick time to finish before the register write
   task automatic set_loop(input bit [LOOP_W-1:0] frames);
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= frames;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
      loop_settings++;
   endtask

   task automatic random_burst(input int budget);
      int                 sent;
      int                 run;
      bit [RATE_W-1:0]    rate;
      bit [STRETCH_W-1:0] stretch;
      sent = 0;
      while (sent < budget) begin
         rate = pick_rate();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               run = $urandom_range(5, 40);
               case ($urandom_range(0, 3))
                  0:       stretch = STRETCH_BYPASS_Q8;
                  1:       stretch = 2560;
                  default: stretch = $urandom_range(STRETCH_BYPASS_Q8, 4095);
               endcase
               repeat (run) tick(rate, stretch);
            end
            5, 6: begin
               run = $urandom_range(3, 20);
               repeat (run) tick(rate, $urandom_range(0, STRETCH_BYPASS_Q8 - 1));
            end
            7: begin
               run = $urandom_range(1, 5);
               repeat (run) load($urandom, $urandom);
            end
            8: begin
               run = 1;
               jump_to($urandom);
            end
            default: begin
               run = 1;
               send(glsp_cmd_type'($urandom_range(0, 3)), random_fields());
            end
         endcase
         sent += run;
      end
   endtask

   // response side: random stalls, and one long hold-off on request
   initial begin
      int stall;
      forever begin
         if (hold_request) begin
            stall = 600;
            hold_request = 0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
         end
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      #200_000_000;
      $display("granular_loop_stretch_player_unit verification failed");
      $finish;
   end

   initial begin
      bit [LOOP_W-1:0] loops [8];
      no_idle = 1;
      hold_request = 0;
      items_sent = 0;
      loop_settings = 0;
      loops = '{16, 0, 17, 64, 1000, 131072, 262143, 5};
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // fill the whole memory so no read can land on an unwritten frame
      for (int a = 0; a < MEM_FRAMES; a++) load(a, $urandom);
      no_idle = 0;

      // directed
      load(0, 24'hFFFFFF);
      load(MEM_FRAMES - 1, 24'h800800);
      load(1, 24'h7FF7FF);
      tick(0, 256);
      tick('1, 0);
      tick(RATE_W'(1) << 32, STRETCH_BYPASS_Q8 - 1);
      tick(RATE_W'(1) << 32, STRETCH_BYPASS_Q8);
      tick('1, 4095);
      tick(0, 2560);
      jump_to(MEM_FRAMES - 1);
      tick(RATE_W'(1) << 31, 256);
      tick(RATE_W'(3) << 30, 512);
      send(CMD_NONE, random_fields());
      jump_to(5);
      tick(RATE_W'(1) << 32, 300);
      tick(RATE_W'(1) << 32, 300);
      set_loop(0);
      jump_to(100);
      tick(RATE_W'(5) << 32, 2560);
      tick(RATE_W'(5) << 32, 100);
      set_loop(262143);
      jump_to(120000);
      tick(RATE_W'(1) << 32, 256);
      // shrink the loop under the playhead
      set_loop(40);
      tick(RATE_W'(1) << 32, 256);
      tick(RATE_W'(1) << 32, 1024);

      // random, several loop settings; one phase has back-pressure from a long hold
      foreach (loops[i]) begin
         set_loop(loops[i]);
         jump_to($urandom);
         if (i == 3) begin
            no_idle = 1;
            hold_request = 1;
            repeat (30) tick(pick_rate(), $urandom_range(0, 4095));
            no_idle = 0;
         end
         random_burst(95);
      end
      set_loop($urandom_range(16, 131072));
      random_burst(60);

      // long unbroken grain run so at least one grain reaches full length and restarts
      set_loop(1000);
      no_idle = 1;
      repeat (1030) tick(RATE_W'(1) << 32, 384);
      no_idle = 0;

      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Run covered %0d transactions under %0d loop settings.", items_sent,
               loop_settings);
      $display("Frames checked: %0d, of which %0d from grain mode.", frames_seen,
               grain_frames);
      if (error_count == 0 && pending == 0) begin
         $display("granular_loop_stretch_player_unit verification clean");
      end else begin
         $display("granular_loop_stretch_player_unit verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/glsp_pkg.sv
rtl/glsp_divider.sv
rtl/glsp_sample_ram.sv
rtl/granular_loop_stretch_player_unit.sv
rtl/glsp_checker.sv
bench/glsp_playback_checker.sv
bench/granular_loop_stretch_player_unit_tb.sv
